@@ hw/rtl/dual_one_wire_temperature_reader_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the dual 1-Wire temperature reader
// Shared concurrent assertion forms used by the port checker.
// ---------------------------------------------------------------------------
`ifndef DUAL_ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH
`define DUAL_ONE_WIRE_TEMPERATURE_READER_DEFINES_SVH

// Same-cycle implication.
`define OWTR_ASSERT_IMP(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("owtr assertion failed");

// Next-cycle implication.
`define OWTR_ASSERT_NXT(lbl, clk, dis, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("owtr assertion failed");

`endif

@@ hw/rtl/owtr_pkg.sv @@
// ---------------------------------------------------------------------------
// owtr_pkg
// Types, codes and constants of the dual 1-Wire temperature reader.
// ---------------------------------------------------------------------------
package owtr_pkg;

    localparam int OWTR_WORD_BITS = 16;
    localparam int TICK_W         = 10;
    localparam int TEMP_W         = 7;
    localparam int STATUS_W       = 4;
    localparam int CMD_W          = 2;
    localparam int REG_IDX_W      = 3;
    localparam int APB_ADDR_W     = 5;
    localparam int APB_DATA_W     = 32;
    localparam int IN_DATA_W      = 8;
    localparam int IN_USER_W      = 3;
    localparam int OUT_DATA_W     = 16;

    // register indexes (byte address = 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_PRES_SAMPLE = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_WR1_LOW     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WR0_LOW     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RD_LOW      = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_RD_SAMPLE   = 3'd4;

    localparam logic [TICK_W-1:0] RST_PRES_SAMPLE = 10'd70;
    localparam logic [TICK_W-1:0] RST_WR1_LOW     = 10'd10;
    localparam logic [TICK_W-1:0] RST_WR0_LOW     = 10'd70;
    localparam logic [TICK_W-1:0] RST_RD_LOW      = 10'd2;
    localparam logic [TICK_W-1:0] RST_RD_SAMPLE   = 10'd10;

    localparam logic [7:0] ROM_SKIP_BYTE = 8'hCC;
    localparam logic [7:0] CONVERT_BYTE  = 8'h44;
    localparam logic [7:0] RD_PAD_BYTE   = 8'hBE;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_STEP = 2'd1,
        CMD_READ = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        SEQ_IDLE  = 4'd0,
        SEQ_RST1  = 4'd1,
        SEQ_PRES1 = 4'd2,
        SEQ_SKIP1 = 4'd3,
        SEQ_CONV  = 4'd4,
        SEQ_POLL  = 4'd5,
        SEQ_RST2  = 4'd6,
        SEQ_PRES2 = 4'd7,
        SEQ_SKIP2 = 4'd8,
        SEQ_RDCMD = 4'd9,
        SEQ_WORD  = 4'd10,
        SEQ_DONE  = 4'd11
    } t_seq;

    typedef enum logic [2:0] {
        SLOT_NONE      = 3'd0,
        SLOT_PRESENCE  = 3'd1,
        SLOT_WRITE_LOW = 3'd2,
        SLOT_READ_LOW  = 3'd3,
        SLOT_READ_WAIT = 3'd4
    } t_slot;

    typedef struct packed {
        logic [TICK_W-1:0] pres_sample;
        logic [TICK_W-1:0] wr1_low;
        logic [TICK_W-1:0] wr0_low;
        logic [TICK_W-1:0] rd_low;
        logic [TICK_W-1:0] rd_sample;
    } t_cfg;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             line_a_level;
        logic             line_b_level;
        logic             sensor_select;
    } t_item;

    typedef struct packed {
        logic [TEMP_W-1:0]   temperature_value;
        logic [STATUS_W-1:0] status;
        logic                slot_busy;
        logic                drive_low;
    } t_result;

    // byte sent in each command-byte position
    function automatic logic [7:0] cmd_byte(input t_seq seq);
        logic [7:0] b;
        unique case (seq)
            SEQ_SKIP1: b = ROM_SKIP_BYTE;
            SEQ_CONV:  b = CONVERT_BYTE;
            SEQ_SKIP2: b = ROM_SKIP_BYTE;
            default:   b = RD_PAD_BYTE;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/dual_one_wire_temperature_reader.sv @@
// ---------------------------------------------------------------------------
// dual_one_wire_temperature_reader
// 1-Wire master for two sensor lines driven in lockstep, stream in/out.
// ---------------------------------------------------------------------------
// Each input item is a command: a 1 us tick that times the running slot, a
// step that starts the next slot of the reset / skip-ROM / convert / poll /
// reset / skip-ROM / read-scratchpad / word-read sequence, or a read that
// returns the chosen sensor's temperature in whole degrees (0 when that
// sensor gave no presence pulse) and returns a finished sequence to idle.
// Every item yields exactly one result item with the line drive, the busy
// flag, the sequence status and the read value. Throughput is one item per
// clock while the output is not stalled; the accepting edge loads the input
// register, and once the output slot is free the single state-update pass
// runs into the result register, which holds the output until it is taken.
// The separate input register lets a new item enter while a result
// waits to be taken. Timing registers are written over APB at byte addresses
// 0x00 (presence sample), 0x04 (write-one low), 0x08 (write-zero low), 0x0C
// (read low) and 0x10 (read sample), 10 bits each; write them only while
// no item is in flight.
// ---------------------------------------------------------------------------
module dual_one_wire_temperature_reader
    import owtr_pkg::*;
#(
    parameter int WORD_BITS = OWTR_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [0] line_a_level, [1] line_b_level
    input  logic [IN_USER_W-1:0]  s_axis_tuser,  // [1:0] command, [2] sensor_select
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] drive_low, [1] slot_busy, [5:2] status, [12:6] temperature_value
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_cfg    w_cfg;
    t_item   r_item;
    t_result w_res;
    t_result r_res;
    logic    r_in_valid, n_in_valid;
    logic    r_out_valid, n_out_valid;
    logic    w_adv;
    logic    w_fire;
    logic    w_s_acc;

    // output slot free or draining this cycle
    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign w_s_acc       = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_in_valid  = r_in_valid;
        n_out_valid = r_out_valid;
        if (w_s_acc) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
        if (w_fire) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    owtr_apb u_apb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // state update happens as the item moves into the result register
    owtr_core #(
        .WORD_BITS (WORD_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_item.command       <= s_axis_tuser[CMD_W-1:0];
            r_item.line_a_level  <= s_axis_tdata[0];
            r_item.line_b_level  <= s_axis_tdata[1];
            r_item.sensor_select <= s_axis_tuser[CMD_W];
        end
        if (w_fire) begin
            r_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_DATA_W'(r_res);

endmodule

@@ hw/rtl/owtr_apb.sv @@
// ---------------------------------------------------------------------------
// owtr_apb
// APB register file holding the five slot timing values.
// ---------------------------------------------------------------------------
module owtr_apb
    import owtr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output t_cfg                  o_cfg
);

    t_cfg                 r_cfg;
    t_cfg                 n_cfg;
    logic [REG_IDX_W-1:0] w_idx;
    logic [TICK_W-1:0]    w_rd;
    logic [TICK_W-1:0]    w_wval;

    assign w_idx  = paddr[APB_ADDR_W-1:2];
    assign w_wval = pwdata[TICK_W-1:0];
    assign pready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_PRES_SAMPLE: n_cfg.pres_sample = w_wval;
                REG_WR1_LOW:     n_cfg.wr1_low     = w_wval;
                REG_WR0_LOW:     n_cfg.wr0_low     = w_wval;
                REG_RD_LOW:      n_cfg.rd_low      = w_wval;
                REG_RD_SAMPLE:   n_cfg.rd_sample   = w_wval;
                default:         ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PRES_SAMPLE: w_rd = r_cfg.pres_sample;
            REG_WR1_LOW:     w_rd = r_cfg.wr1_low;
            REG_WR0_LOW:     w_rd = r_cfg.wr0_low;
            REG_RD_LOW:      w_rd = r_cfg.rd_low;
            REG_RD_SAMPLE:   w_rd = r_cfg.rd_sample;
            default:         w_rd = '0;
        endcase
    end

    assign prdata = APB_DATA_W'(w_rd);
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pres_sample <= RST_PRES_SAMPLE;
            r_cfg.wr1_low     <= RST_WR1_LOW;
            r_cfg.wr0_low     <= RST_WR0_LOW;
            r_cfg.rd_low      <= RST_RD_LOW;
            r_cfg.rd_sample   <= RST_RD_SAMPLE;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

@@ hw/rtl/owtr_core.sv @@
// ---------------------------------------------------------------------------
// owtr_core
// Sequencer state and the one-pass update applied to each item.
// ---------------------------------------------------------------------------
module owtr_core
    import owtr_pkg::*;
#(
    parameter int WORD_BITS = OWTR_WORD_BITS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    input  t_cfg    i_cfg,
    output t_result o_res
);

    localparam int CNT_W = $clog2(WORD_BITS + 1);
    localparam int IDX_W = $clog2(WORD_BITS);

    t_seq                r_seq,    n_seq;
    t_slot               r_slot,   n_slot;
    logic [TICK_W-1:0]   r_timer,  n_timer;
    logic [CNT_W-1:0]    r_cnt,    n_cnt;
    logic                r_low,    n_low;
    logic [WORD_BITS-1:0] r_shift_a, n_shift_a;
    logic [WORD_BITS-1:0] r_shift_b, n_shift_b;
    logic [TEMP_W-1:0]   r_temp_a, n_temp_a;
    logic [TEMP_W-1:0]   r_temp_b, n_temp_b;
    logic                r_err_a,  n_err_a;
    logic                r_err_b,  n_err_b;
    logic [TEMP_W-1:0]   w_tv;
    logic [7:0]          w_byte;

    assign w_byte = cmd_byte(r_seq);

    always_comb begin
        n_seq     = r_seq;
        n_slot    = r_slot;
        n_timer   = r_timer;
        n_cnt     = r_cnt;
        n_low     = r_low;
        n_shift_a = r_shift_a;
        n_shift_b = r_shift_b;
        n_temp_a  = r_temp_a;
        n_temp_b  = r_temp_b;
        n_err_a   = r_err_a;
        n_err_b   = r_err_b;
        w_tv      = '0;
        if (i_fire) begin
            unique case (i_item.command)
                CMD_TICK: begin
                    if (r_slot != SLOT_NONE) begin
                        if (r_timer > TICK_W'(1)) begin
                            n_timer = r_timer - TICK_W'(1);
                        end else begin
                            n_timer = '0;
                            unique case (r_slot)
                                SLOT_PRESENCE: begin
                                    n_err_a = i_item.line_a_level;
                                    n_err_b = i_item.line_b_level;
                                    n_slot  = SLOT_NONE;
                                    n_seq   = t_seq'(STATUS_W'(r_seq) + STATUS_W'(1));
                                end
                                SLOT_WRITE_LOW: begin
                                    n_low  = 1'b0;
                                    n_slot = SLOT_NONE;
                                end
                                SLOT_READ_LOW: begin
                                    n_slot  = SLOT_READ_WAIT;
                                    n_timer = i_cfg.rd_sample;
                                    n_low   = 1'b0;
                                end
                                default: begin
                                    n_slot = SLOT_NONE;
                                    if (r_seq == SEQ_POLL) begin
                                        if (i_item.line_a_level) begin
                                            n_seq = SEQ_RST2;
                                        end
                                    end else if (r_seq == SEQ_WORD &&
                                                 r_cnt < CNT_W'(WORD_BITS)) begin
                                        n_shift_a[r_cnt[IDX_W-1:0]] = i_item.line_a_level;
                                        n_shift_b[r_cnt[IDX_W-1:0]] = i_item.line_b_level;
                                        n_cnt = r_cnt + CNT_W'(1);
                                    end
                                end
                            endcase
                        end
                    end
                end
                CMD_STEP: begin
                    if (r_slot == SLOT_NONE) begin
                        unique case (r_seq)
                            SEQ_IDLE, SEQ_RST1, SEQ_RST2: begin
                                n_low = 1'b1;
                                n_cnt = '0;
                                n_seq = (r_seq == SEQ_RST2) ? SEQ_PRES2 : SEQ_PRES1;
                            end
                            SEQ_PRES1, SEQ_PRES2: begin
                                n_slot  = SLOT_PRESENCE;
                                n_timer = i_cfg.pres_sample;
                                n_low   = 1'b0;
                            end
                            SEQ_SKIP1, SEQ_CONV, SEQ_SKIP2, SEQ_RDCMD: begin
                                if (r_cnt >= CNT_W'(8)) begin
                                    n_cnt = '0;
                                    n_low = 1'b0;
                                    n_seq = t_seq'(STATUS_W'(r_seq) + STATUS_W'(1));
                                end else begin
                                    n_slot  = SLOT_WRITE_LOW;
                                    n_timer = w_byte[r_cnt[2:0]] ? i_cfg.wr1_low
                                                                 : i_cfg.wr0_low;
                                    n_low   = 1'b1;
                                    n_cnt   = r_cnt + CNT_W'(1);
                                end
                            end
                            SEQ_POLL: begin
                                n_slot  = SLOT_READ_LOW;
                                n_timer = i_cfg.rd_low;
                                n_low   = 1'b1;
                            end
                            SEQ_WORD: begin
                                if (r_cnt >= CNT_W'(WORD_BITS)) begin
                                    n_temp_a = r_shift_a[7:1];
                                    n_temp_b = r_shift_b[7:1];
                                    n_cnt    = '0;
                                    n_seq    = SEQ_DONE;
                                end else begin
                                    if (r_cnt == '0) begin
                                        n_shift_a = '0;
                                        n_shift_b = '0;
                                    end
                                    n_slot  = SLOT_READ_LOW;
                                    n_timer = i_cfg.rd_low;
                                    n_low   = 1'b1;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                CMD_READ: begin
                    if (r_seq == SEQ_DONE) begin
                        n_seq = SEQ_IDLE;
                    end
                    if (i_item.sensor_select) begin
                        w_tv = r_err_b ? '0 : r_temp_b;
                    end else begin
                        w_tv = r_err_a ? '0 : r_temp_a;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_res.drive_low         = n_low;
    assign o_res.slot_busy         = (n_slot != SLOT_NONE);
    assign o_res.status            = n_seq;
    assign o_res.temperature_value = w_tv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq     <= SEQ_IDLE;
            r_slot    <= SLOT_NONE;
            r_timer   <= '0;
            r_cnt     <= '0;
            r_low     <= 1'b0;
            r_shift_a <= '0;
            r_shift_b <= '0;
            r_temp_a  <= '0;
            r_temp_b  <= '0;
            r_err_a   <= 1'b0;
            r_err_b   <= 1'b0;
        end else begin
            r_seq     <= n_seq;
            r_slot    <= n_slot;
            r_timer   <= n_timer;
            r_cnt     <= n_cnt;
            r_low     <= n_low;
            r_shift_a <= n_shift_a;
            r_shift_b <= n_shift_b;
            r_temp_a  <= n_temp_a;
            r_temp_b  <= n_temp_b;
            r_err_a   <= n_err_a;
            r_err_b   <= n_err_b;
        end
    end

endmodule

@@ hw/rtl/owtr_chk.sv @@
// ---------------------------------------------------------------------------
// owtr_chk
// Port-level checks of the dual 1-Wire temperature reader, bound to the top.
// ---------------------------------------------------------------------------
`include "dual_one_wire_temperature_reader_defines.svh"

module owtr_chk
    import owtr_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // no result shows right after reset
    `OWTR_ASSERT_NXT(a_rst_empty, i_clk, 1'b0, !i_rst_n, !m_axis_tvalid)

    // a stalled result holds
    `OWTR_ASSERT_NXT(a_stall_hold, i_clk, !i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // a timed slot runs only inside the running positions
    `OWTR_ASSERT_IMP(a_busy_running, i_clk, !i_rst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tdata[5:2] >= SEQ_PRES1 && m_axis_tdata[5:2] <= SEQ_WORD)

    // idle and data ready leave the lines released and no slot open
    `OWTR_ASSERT_IMP(a_idle_quiet, i_clk, !i_rst_n, m_axis_tvalid && (m_axis_tdata[5:2] == SEQ_IDLE || m_axis_tdata[5:2] == SEQ_DONE), !m_axis_tdata[0] && !m_axis_tdata[1])

endmodule

bind dual_one_wire_temperature_reader owtr_chk u_owtr_chk (.*);

@@ verif/dual_one_wire_temperature_reader_test.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// dual_one_wire_temperature_reader_test
// Self-checking stream testbench for the dual 1-Wire temperature reader.
// ---------------------------------------------------------------------------
// Every command item gives one result item. Each accepted command runs a
// local copy of the sequencer (slot timer, bit counter, shift registers,
// presence flags), and the result that copy gives is queued. Results are
// compared field by field in arrival order. A short directed table covers
// the states just after reset. Biased random commands then walk full
// read sequences under several timing settings, the zero extreme among
// them, and open long slots at the all-ones extreme. The sender pauses in
// bursts and the receiver stalls on its own pattern, and it holds off once
// for a long stretch.
// ---------------------------------------------------------------------------
module dual_one_wire_temperature_reader_test;
    import owtr_pkg::*;

    localparam int                 CYCLE_LIMIT  = 400000;
    localparam int                 LONG_HOLD    = 400;
    localparam int                 HOLD_AFTER   = 250;
    localparam logic [CMD_W-1:0]   CMD_UNUSED   = 2'd3;
    localparam int                 RESULT_W     = $bits(t_result);

    // one row of the directed table: command plus an optional hand-typed result
    typedef struct packed {
        t_item   item;
        logic    checked;
        t_result want;
    } t_row;

    // result fields listed as {temperature_value, status, slot_busy, drive_low}
    localparam int NUM_ROWS = 12;
    localparam t_row DIRECTED_ROWS [NUM_ROWS] = '{
        // reads and idle ticks straight after reset: everything zero
        '{'{CMD_READ, 1'b0, 1'b0, 1'b0}, 1'b1, '{7'd0, SEQ_IDLE, 1'b0, 1'b0}},
        '{'{CMD_READ, 1'b1, 1'b1, 1'b1}, 1'b1, '{7'd0, SEQ_IDLE, 1'b0, 1'b0}},
        '{'{CMD_TICK, 1'b1, 1'b1, 1'b0}, 1'b1, '{7'd0, SEQ_IDLE, 1'b0, 1'b0}},
        // unused command code leaves everything alone
        '{'{CMD_UNUSED, 1'b1, 1'b1, 1'b1}, 1'b1, '{7'd0, SEQ_IDLE, 1'b0, 1'b0}},
        // first step pulls the lines low and lands on presence
        '{'{CMD_STEP, 1'b0, 1'b0, 1'b0}, 1'b1, '{7'd0, SEQ_PRES1, 1'b0, 1'b1}},
        // second step releases and opens the presence slot
        '{'{CMD_STEP, 1'b1, 1'b0, 1'b1}, 1'b1, '{7'd0, SEQ_PRES1, 1'b1, 1'b0}},
        // step while the slot runs is dropped
        '{'{CMD_STEP, 1'b0, 1'b1, 1'b0}, 1'b1, '{7'd0, SEQ_PRES1, 1'b1, 1'b0}},
        // read mid-sequence: value from the empty word, status unchanged
        '{'{CMD_READ, 1'b0, 1'b0, 1'b1}, 1'b1, '{7'd0, SEQ_PRES1, 1'b1, 1'b0}},
        '{'{CMD_UNUSED, 1'b0, 1'b0, 1'b0}, 1'b1, '{7'd0, SEQ_PRES1, 1'b1, 1'b0}},
        '{'{CMD_TICK, 1'b1, 1'b0, 1'b0}, 1'b1, '{7'd0, SEQ_PRES1, 1'b1, 1'b0}},
        '{'{CMD_TICK, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
        '{'{CMD_READ, 1'b0, 1'b0, 1'b0}, 1'b0, '0}
    };

    // ---------------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;  // [0] line_a_level, [1] line_b_level
    logic [IN_USER_W-1:0]  s_axis_tuser  = '0;  // [1:0] command, [2] sensor_select
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [0] drive_low, [1] slot_busy, [5:2] status, [12:6] temperature_value
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [APB_DATA_W-1:0] pwdata        = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    dual_one_wire_temperature_reader u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------------
    // Sequencer copy: timing registers and state, all at reset values
    // ---------------------------------------------------------------------
    t_cfg        timing = '{RST_PRES_SAMPLE, RST_WR1_LOW, RST_WR0_LOW, RST_RD_LOW,
                            RST_RD_SAMPLE};
    t_seq        seq_pos    = SEQ_IDLE;
    t_slot       slot_now   = SLOT_NONE;
    logic [4:0]  bit_idx    = '0;
    logic [TICK_W-1:0] slot_ticks = '0;
    logic        lines_low  = 1'b0;
    logic [15:0] shift_reg [2] = '{16'h0, 16'h0};
    logic [15:0] temp_word [2] = '{16'h0, 16'h0};
    logic        pres_err  [2] = '{1'b0, 1'b0};

    t_result     expected_readings [$];
    int          mismatch_count = 0;
    int          items_accepted = 0;
    int          cycle_count    = 0;
    bit          long_hold_done = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        mismatch_count++;
    endtask

    // Apply one command to the sequencer copy and return the result it gives.
    task automatic advance_sensor_model(input t_item it, output t_result res);
        logic [7:0] cmd_bits;
        logic [6:0] reading;
        logic       la;
        logic       lb;
        reading = '0;
        la      = it.line_a_level;
        lb      = it.line_b_level;
        case (it.command)
            CMD_TICK: begin
                // ticks only matter while a slot runs; a zero count ends on the first
                if (slot_now != SLOT_NONE) begin
                    if (slot_ticks > 1) begin
                        slot_ticks = slot_ticks - 1'b1;
                    end else begin
                        slot_ticks = '0;
                        case (slot_now)
                            SLOT_PRESENCE: begin
                                // a high line at the sample point means no sensor
                                pres_err[0] = la;
                                pres_err[1] = lb;
                                slot_now    = SLOT_NONE;
                                seq_pos     = t_seq'(seq_pos + 4'd1);
                            end
                            SLOT_WRITE_LOW: begin
                                lines_low = 1'b0;
                                slot_now  = SLOT_NONE;
                            end
                            SLOT_READ_LOW: begin
                                slot_now   = SLOT_READ_WAIT;
                                slot_ticks = timing.rd_sample;
                                lines_low  = 1'b0;
                            end
                            default: begin
                                slot_now = SLOT_NONE;
                                if (seq_pos == SEQ_POLL) begin
                                    // conversion finished once line a reads high
                                    if (la) seq_pos = SEQ_RST2;
                                end else if (seq_pos == SEQ_WORD &&
                                             bit_idx < OWTR_WORD_BITS) begin
                                    shift_reg[0][bit_idx[3:0]] =
                                        shift_reg[0][bit_idx[3:0]] | la;
                                    shift_reg[1][bit_idx[3:0]] =
                                        shift_reg[1][bit_idx[3:0]] | lb;
                                    bit_idx = bit_idx + 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            CMD_STEP: begin
                if (slot_now == SLOT_NONE) begin
                    case (seq_pos)
                        SEQ_IDLE, SEQ_RST1, SEQ_RST2: begin
                            lines_low = 1'b1;
                            bit_idx   = '0;
                            seq_pos   = (seq_pos == SEQ_RST2) ? SEQ_PRES2 : SEQ_PRES1;
                        end
                        SEQ_PRES1, SEQ_PRES2: begin
                            slot_now   = SLOT_PRESENCE;
                            slot_ticks = timing.pres_sample;
                            lines_low  = 1'b0;
                        end
                        SEQ_SKIP1, SEQ_CONV, SEQ_SKIP2, SEQ_RDCMD: begin
                            if (bit_idx >= 8) begin
                                // ninth step closes the byte
                                bit_idx   = '0;
                                lines_low = 1'b0;
                                seq_pos   = t_seq'(seq_pos + 4'd1);
                            end else begin
                                case (seq_pos)
                                    SEQ_CONV:  cmd_bits = CONVERT_BYTE;
                                    SEQ_RDCMD: cmd_bits = RD_PAD_BYTE;
                                    default:   cmd_bits = ROM_SKIP_BYTE;
                                endcase
                                slot_now   = SLOT_WRITE_LOW;
                                slot_ticks = cmd_bits[bit_idx[2:0]] ? timing.wr1_low
                                                                    : timing.wr0_low;
                                lines_low  = 1'b1;
                                bit_idx    = bit_idx + 1'b1;
                            end
                        end
                        SEQ_POLL: begin
                            slot_now   = SLOT_READ_LOW;
                            slot_ticks = timing.rd_low;
                            lines_low  = 1'b1;
                        end
                        SEQ_WORD: begin
                            if (bit_idx >= OWTR_WORD_BITS) begin
                                temp_word[0] = shift_reg[0];
                                temp_word[1] = shift_reg[1];
                                bit_idx      = '0;
                                seq_pos      = SEQ_DONE;
                            end else begin
                                if (bit_idx == 0) begin
                                    shift_reg[0] = '0;
                                    shift_reg[1] = '0;
                                end
                                slot_now   = SLOT_READ_LOW;
                                slot_ticks = timing.rd_low;
                                lines_low  = 1'b1;
                            end
                        end
                        default: ;  // data ready: wait for a read
                    endcase
                end
            end
            CMD_READ: begin
                if (seq_pos == SEQ_DONE) seq_pos = SEQ_IDLE;
                if (!pres_err[it.sensor_select])
                    reading = temp_word[it.sensor_select][7:1];
            end
            default: ;
        endcase
        res.drive_low         = lines_low;
        res.slot_busy         = (slot_now != SLOT_NONE);
        res.status            = seq_pos;
        res.temperature_value = reading;
    endtask

    // ---------------------------------------------------------------------
    // Command sender
    // ---------------------------------------------------------------------
    // Offer one item and hold it until taken. tvalid stays high afterwards so
    // a back-to-back item needs no second assignment in the same step.
    task automatic send_command(input t_item it, input logic use_typed,
                                input t_result typed);
        t_result predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W-2){1'b0}}, it.line_b_level, it.line_a_level};
        s_axis_tuser  <= {it.sensor_select, it.command};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        advance_sensor_model(it, predicted);
        expected_readings.push_back(use_typed ? typed : predicted);
        items_accepted++;
    endtask

    task automatic pause_sender(input int max_gap);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Mostly the command that moves the sequence on (tick while a slot runs,
    // read once done, step otherwise) with random line levels; the rest is
    // noise: any code, any field.
    task automatic choose_command(output t_item it);
        int roll;
        roll             = $urandom_range(0, 99);
        it.line_a_level  = 1'($urandom_range(0, 1));
        it.line_b_level  = 1'($urandom_range(0, 1));
        it.sensor_select = 1'($urandom_range(0, 1));
        if (roll < 12)
            it.command = CMD_W'($urandom_range(0, 3));
        else if (slot_now != SLOT_NONE)
            it.command = CMD_TICK;
        else if (seq_pos == SEQ_DONE || roll < 16)
            it.command = CMD_READ;
        else
            it.command = CMD_STEP;
    endtask

    task automatic run_items(input int count);
        t_item it;
        int    burst;
        while (count > 0) begin
            burst = $urandom_range(1, 24);
            while (burst > 0 && count > 0) begin
                choose_command(it);
                send_command(it, 1'b0, '0);
                burst--;
                count--;
            end
            pause_sender($urandom_range(0, 1) ? 8 : 0);
        end
    endtask

    // Drop tvalid and let every queued result drain before touching registers.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------------
    // APB access: setup, access, then idle; read data is checked in the access cycle
    // ---------------------------------------------------------------------
    task automatic apb_access(input logic [REG_IDX_W-1:0] idx, input logic wr,
                              input logic [TICK_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        // register written / read data valid at this edge
        if (!wr && prdata !== APB_DATA_W'(value))
            report_mismatch($sformatf("register %0d reads %h, want %h", idx, prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_timing(input t_cfg c);
        apb_access(REG_PRES_SAMPLE, 1'b1, c.pres_sample);
        apb_access(REG_WR1_LOW,     1'b1, c.wr1_low);
        apb_access(REG_WR0_LOW,     1'b1, c.wr0_low);
        apb_access(REG_RD_LOW,      1'b1, c.rd_low);
        apb_access(REG_RD_SAMPLE,   1'b1, c.rd_sample);
        timing = c;
        apb_access(REG_PRES_SAMPLE, 1'b0, c.pres_sample);
        apb_access(REG_WR1_LOW,     1'b0, c.wr1_low);
        apb_access(REG_WR0_LOW,     1'b0, c.wr0_low);
        apb_access(REG_RD_LOW,      1'b0, c.rd_low);
        apb_access(REG_RD_SAMPLE,   1'b0, c.rd_sample);
    endtask

    // ---------------------------------------------------------------------
    // Result receiver: stall pattern of its own, plus one long hold-off
    // while the sender keeps offering, so the block backs up into its input.
    // ---------------------------------------------------------------------
    initial begin : result_sink
        int mode;
        int span;
        forever begin
            mode = $urandom_range(0, 2);
            span = $urandom_range(1, 40);
            while (span > 0) begin
                if (!long_hold_done && items_accepted >= HOLD_AFTER) begin
                    long_hold_done = 1'b1;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end else begin
                    case (mode)
                        0:       m_axis_tready <= 1'b1;
                        1:       m_axis_tready <= 1'($urandom_range(0, 1));
                        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                    @(posedge i_clk);
                end
                span--;
            end
        end
    end

    // Compare each taken result against the oldest expectation.
    always @(posedge i_clk) begin : result_check
        t_result got;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[RESULT_W-1:0]);
            if (expected_readings.size() == 0) begin
                report_mismatch($sformatf("result %h with nothing expected", got));
            end else begin
                want = expected_readings.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch($sformatf("drive_low %b, want %b",
                                              got.drive_low, want.drive_low));
                if (got.slot_busy !== want.slot_busy)
                    report_mismatch($sformatf("slot_busy %b, want %b",
                                              got.slot_busy, want.slot_busy));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              got.status, want.status));
                if (got.temperature_value !== want.temperature_value)
                    report_mismatch($sformatf("temperature %0d, want %0d",
                                              got.temperature_value,
                                              want.temperature_value));
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin : main_flow
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers come up at their reset values
        apb_access(REG_PRES_SAMPLE, 1'b0, RST_PRES_SAMPLE);
        apb_access(REG_WR1_LOW,     1'b0, RST_WR1_LOW);
        apb_access(REG_WR0_LOW,     1'b0, RST_WR0_LOW);
        apb_access(REG_RD_LOW,      1'b0, RST_RD_LOW);
        apb_access(REG_RD_SAMPLE,   1'b0, RST_RD_SAMPLE);

        // directed rows, then random traffic under reset timing
        for (int i = 0; i < NUM_ROWS; i++) begin
            send_command(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].checked,
                         DIRECTED_ROWS[i].want);
            pause_sender(2);
        end
        run_items(60);
        settle();

        // zero counts behave as one tick: shortest possible sequences
        set_timing('{10'd0, 10'd0, 10'd0, 10'd0, 10'd0});
        run_items(120);
        settle();

        // short random timing; the long receiver hold-off lands here
        set_timing('{TICK_W'($urandom_range(1, 3)), TICK_W'($urandom_range(1, 3)),
                     TICK_W'($urandom_range(1, 3)), TICK_W'($urandom_range(1, 3)),
                     TICK_W'($urandom_range(1, 3))});
        run_items(100);
        settle();

        // all counts at the top of the range; the first slot opened here is still
        // counting down when this phase ends
        set_timing('{10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023});
        run_items(120);
        settle();

        // mixed small settings, each register drawn on its own
        set_timing('{TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)),
                     TICK_W'($urandom_range(1, 6)), TICK_W'($urandom_range(1, 6)),
                     TICK_W'($urandom_range(1, 6))});
        run_items(90);

        s_axis_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
